/* hdl/lte_pkg.sv */
package lte_pkg;

  localparam int unsigned PT_W      = 16;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned ETA_W     = 12;
  localparam int unsigned PHI_W     = 13;
  localparam int unsigned CHG_W     = 2;
  localparam int unsigned PROC_W    = 10;
  localparam int unsigned JCNT_W    = 8;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // Reset values of the threshold registers, in 0.25 GeV units.
  localparam logic [PT_W-1:0] LEP_SEL_RST = 16'd60;
  localparam logic [PT_W-1:0] LEP_MIN_RST = 16'd80;
  localparam logic [PT_W-1:0] JET_MIN_RST = 16'd80;
  localparam logic [PT_W-1:0] TAU_MIN_RST = 16'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_LEP_SEL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEP_MIN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JET_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAU_MIN = 8'd3;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_ELECTRON = 3'd1,
    OP_MUON     = 3'd2,
    OP_JET      = 3'd3,
    OP_END      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_SUMMARY = 3'd0,
    KIND_LEPTON  = 3'd1,
    KIND_TAU     = 3'd2,
    KIND_LEAD    = 3'd3,
    KIND_SUB     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    STG_NONE   = 3'd1,
    STG_LEPTON = 3'd2,
    STG_LEP_PT = 3'd3,
    STG_TAU    = 3'd4,
    STG_CHARGE = 3'd5,
    STG_PASS   = 3'd6
  } stage_e;

  typedef struct packed {
    logic [PT_W-1:0] lep_sel;
    logic [PT_W-1:0] lep_min;
    logic [PT_W-1:0] jet_min;
    logic [PT_W-1:0] tau_min;
  } cfg_t;

  typedef struct packed {
    logic [2:0]              operation;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    logic signed [CHG_W-1:0] charge;
    logic                    tau_tag;
    logic [PROC_W-1:0]       proc_num;
  } item_t;

  typedef struct packed {
    logic                    valid;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    logic signed [CHG_W-1:0] chg;
    logic                    ele;
  } obj_t;

  localparam obj_t OBJ_NONE = '0;

  // Everything the record sequencer needs from one finished event.
  typedef struct packed {
    logic               passed;
    logic [2:0]         stage;
    logic [JCNT_W-1:0]  jet_count;
    logic [SUM_W-1:0]   jet_sum;
    logic [PROC_W-1:0]  process;
    obj_t               lep;
    obj_t               tau;
    obj_t               lead;
    obj_t               sub;
  } snap_t;

  typedef struct packed {
    logic [2:0]              record_kind;
    logic                    valid_res;
    logic [SUM_W-1:0]        pt_value;
    logic signed [ETA_W-1:0] eta_value;
    logic signed [PHI_W-1:0] phi_value;
    logic signed [CHG_W-1:0] charge_value;
    logic                    lepton_is_electron;
    logic [JCNT_W-1:0]       jet_count;
    logic                    passed;
    logic [2:0]              cuts_passed;
    logic [PROC_W-1:0]       event_process;
    logic                    last_record;
  } rec_t;

endpackage

/* hdl/lte_item_if.sv */
interface lte_item_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [15:0]       pt;
  logic signed [11:0] eta;
  logic signed [12:0] phi;
  logic signed [1:0] charge;
  logic              tau_tag;
  logic [9:0]        proc_num;

  modport source (
    output valid, operation, pt, eta, phi, charge, tau_tag, proc_num,
    input  ready
  );
  modport sink (
    input  valid, operation, pt, eta, phi, charge, tau_tag, proc_num,
    output ready
  );
endinterface

/* hdl/lte_rec_if.sv */
interface lte_rec_if;
  logic               valid;
  logic               ready;
  logic [2:0]         record_kind;
  logic               valid_res;
  logic [19:0]        pt_value;
  logic signed [11:0] eta_value;
  logic signed [12:0] phi_value;
  logic signed [1:0]  charge_value;
  logic               lepton_is_electron;
  logic [7:0]         jet_count;
  logic               passed;
  logic [2:0]         cuts_passed;
  logic [9:0]         event_process;
  logic               last_record;

  modport source (
    output valid, record_kind, valid_res, pt_value, eta_value, phi_value, charge_value,
           lepton_is_electron, jet_count, passed, cuts_passed, event_process, last_record,
    input  ready
  );
  modport sink (
    input  valid, record_kind, valid_res, pt_value, eta_value, phi_value, charge_value,
           lepton_is_electron, jet_count, passed, cuts_passed, event_process, last_record,
    output ready
  );
endinterface

/* hdl/lte_cfg_if.sv */
interface lte_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/lepton_tau_event_selector_core.sv */
// Lepton plus hadronic-tau event selector. Items arrive on evt_i as start,
// electron, muon, jet and end beats, and the block accepts one beat per clock
// unless an end beat waits. Every beat is first captured in an input register,
// and the next cycle a single pass of logic folds it into the event state:
// leptons above the selection threshold, tau-tagged jets and the other jets
// (count, saturating pt sum and the two highest-pt jets). An end beat runs the
// cut chain in that same cycle and copies the event summary into a record
// buffer, clearing the event state so the next event can stream in immediately.
// The buffer then drives rec_o with one record per beat: just the summary for a
// failing event, or summary, lepton, tau, leading jet and subleading jet for a
// passing one, the last flagged with last_record. Object beats never wait on
// record output themselves; an end beat waits in the input register, holding
// back the beats behind it, until the final record of the previous event
// leaves, so back-to-back events sustain one beat per cycle as long as rec_o
// stays ready and each event has at least as many beats as the previous one
// emits records. Thresholds are written through cfg_i, index 0 to 3, and must
// only change while the block is idle.
module lepton_tau_event_selector_core import lte_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  lte_item_if.sink   evt_i,
  lte_rec_if.source  rec_o,
  lte_cfg_if.sink    cfg_i
);

  cfg_t  cfg_q;
  item_t item;
  snap_t snap;
  rec_t  rec;
  logic  emit_load;
  logic  emit_free;
  logic  rec_valid;

  // Threshold registers; writes to unknown indexes are accepted and dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lep_sel <= LEP_SEL_RST;
      cfg_q.lep_min <= LEP_MIN_RST;
      cfg_q.jet_min <= JET_MIN_RST;
      cfg_q.tau_min <= TAU_MIN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LEP_SEL: cfg_q.lep_sel <= cfg_i.data;
        CFG_LEP_MIN: cfg_q.lep_min <= cfg_i.data;
        CFG_JET_MIN: cfg_q.jet_min <= cfg_i.data;
        CFG_TAU_MIN: cfg_q.tau_min <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item.operation = evt_i.operation;
    item.pt        = evt_i.pt;
    item.eta       = evt_i.eta;
    item.phi       = evt_i.phi;
    item.charge    = evt_i.charge;
    item.tau_tag   = evt_i.tau_tag;
    item.proc_num  = evt_i.proc_num;
  end

  lte_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (evt_i.valid),
    .item_ready_o (evt_i.ready),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .emit_free_i  (emit_free),
    .load_o       (emit_load),
    .snap_o       (snap)
  );

  lte_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit_load),
    .snap_i      (snap),
    .emit_free_o (emit_free),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_o.ready),
    .rec_o       (rec)
  );

  assign rec_o.valid              = rec_valid;
  assign rec_o.record_kind        = rec.record_kind;
  assign rec_o.valid_res          = rec.valid_res;
  assign rec_o.pt_value           = rec.pt_value;
  assign rec_o.eta_value          = rec.eta_value;
  assign rec_o.phi_value          = rec.phi_value;
  assign rec_o.charge_value       = rec.charge_value;
  assign rec_o.lepton_is_electron = rec.lepton_is_electron;
  assign rec_o.jet_count          = rec.jet_count;
  assign rec_o.passed             = rec.passed;
  assign rec_o.cuts_passed        = rec.cuts_passed;
  assign rec_o.event_process      = rec.event_process;
  assign rec_o.last_record        = rec.last_record;

  // A new event summary only enters the buffer once the previous one is done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |-> emit_free)
    else $error("record buffer overwritten while busy");

  // A failing event produces exactly one record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid && !rec.passed) |-> rec.last_record)
    else $error("failing event emitted more than one record");

  // Within a passing event the record kinds follow one another without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid && rec_o.ready && !rec.last_record) |=>
      (rec_valid && (rec.record_kind == $past(rec.record_kind) + 3'd1)))
    else $error("record sequence broken");

  // The pass flag and the deepest stage agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> (rec.passed == (rec.cuts_passed == STG_PASS)))
    else $error("pass flag disagrees with cut stage");

endmodule

/* hdl/lte_accum.sv */
module lte_accum import lte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  output logic  item_ready_o,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  input  logic  emit_free_i,
  output logic  load_o,
  output snap_t snap_o
);

  logic              vld_q;
  item_t             item_q;
  logic              proc_fire;
  op_e               op;

  logic [CNT_W-1:0]  ele_cnt_q, ele_cnt_d;
  logic [CNT_W-1:0]  mu_cnt_q, mu_cnt_d;
  logic [CNT_W-1:0]  tau_cnt_q, tau_cnt_d;
  obj_t              lep_q, lep_d;
  obj_t              tau_q, tau_d;
  obj_t              lead_q, lead_d;
  obj_t              sub_q, sub_d;
  logic [JCNT_W-1:0] jcnt_q, jcnt_d;
  logic [SUM_W-1:0]  jsum_q, jsum_d;
  logic [PROC_W-1:0] proc_q, proc_d;

  obj_t              new_obj;
  logic [SUM_W:0]    sum_ext;
  logic [2:0]        chg_sum;
  stage_e            stage;

  assign op           = op_e'(item_q.operation);
  assign proc_fire    = vld_q && ((op != OP_END) || emit_free_i);
  assign item_ready_o = !vld_q || proc_fire;
  assign load_o       = proc_fire && (op == OP_END);

  always_comb begin
    new_obj.valid = 1'b1;
    new_obj.pt    = item_q.pt;
    new_obj.eta   = item_q.eta;
    new_obj.phi   = item_q.phi;
    new_obj.chg   = item_q.charge;
    new_obj.ele   = (op == OP_ELECTRON);
  end

  assign sum_ext = {1'b0, jsum_q} + (SUM_W+1)'(item_q.pt);

  always_comb begin
    ele_cnt_d = ele_cnt_q;
    mu_cnt_d  = mu_cnt_q;
    tau_cnt_d = tau_cnt_q;
    lep_d     = lep_q;
    tau_d     = tau_q;
    lead_d    = lead_q;
    sub_d     = sub_q;
    jcnt_d    = jcnt_q;
    jsum_d    = jsum_q;
    proc_d    = proc_q;
    if (proc_fire) begin
      case (op)
        OP_START, OP_END: begin
          ele_cnt_d = '0;
          mu_cnt_d  = '0;
          tau_cnt_d = '0;
          lep_d     = OBJ_NONE;
          tau_d     = OBJ_NONE;
          lead_d    = OBJ_NONE;
          sub_d     = OBJ_NONE;
          jcnt_d    = '0;
          jsum_d    = '0;
          if (op == OP_START) begin
            proc_d = item_q.proc_num;
          end
        end
        OP_ELECTRON, OP_MUON: begin
          if (item_q.pt > cfg_i.lep_sel) begin
            if (op == OP_ELECTRON) begin
              if (ele_cnt_q != '1) ele_cnt_d = ele_cnt_q + 1'b1;
            end else begin
              if (mu_cnt_q != '1) mu_cnt_d = mu_cnt_q + 1'b1;
            end
            lep_d = new_obj;
          end
        end
        OP_JET: begin
          if (item_q.pt >= cfg_i.jet_min) begin
            if (item_q.tau_tag) begin
              if (tau_cnt_q != '1) tau_cnt_d = tau_cnt_q + 1'b1;
              tau_d = new_obj;
            end else begin
              if (jcnt_q != '1) jcnt_d = jcnt_q + 1'b1;
              jsum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
              if (!lead_q.valid || (item_q.pt > lead_q.pt)) begin
                sub_d  = lead_q;
                lead_d = new_obj;
              end else if (!sub_q.valid || (item_q.pt > sub_q.pt)) begin
                sub_d = new_obj;
              end
            end
          end
        end
        default: begin
          // Unused operation codes leave the event untouched.
        end
      endcase
    end
  end

  // Cut chain over the accumulated event.
  assign chg_sum = {lep_q.chg[1], lep_q.chg} + {tau_q.chg[1], tau_q.chg};

  always_comb begin
    stage = STG_NONE;
    if ((ele_cnt_q <= 2'd1) && (mu_cnt_q <= 2'd1) && (ele_cnt_q != mu_cnt_q)) begin
      stage = STG_LEPTON;
      if (lep_q.pt >= cfg_i.lep_min) begin
        stage = STG_LEP_PT;
        if (tau_cnt_q == 2'd1) begin
          stage = STG_TAU;
          if (chg_sum == 3'd0) begin
            stage = STG_CHARGE;
            if (tau_q.pt >= cfg_i.tau_min) stage = STG_PASS;
          end
        end
      end
    end
  end

  always_comb begin
    snap_o.passed    = (stage == STG_PASS);
    snap_o.stage     = stage;
    snap_o.jet_count = jcnt_q;
    snap_o.jet_sum   = jsum_q;
    snap_o.process   = proc_q;
    snap_o.lep       = lep_q;
    snap_o.tau       = tau_q;
    snap_o.lead      = lead_q;
    snap_o.sub       = sub_q;
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      ele_cnt_q <= '0;
      mu_cnt_q  <= '0;
      tau_cnt_q <= '0;
      lep_q     <= OBJ_NONE;
      tau_q     <= OBJ_NONE;
      lead_q    <= OBJ_NONE;
      sub_q     <= OBJ_NONE;
      jcnt_q    <= '0;
      jsum_q    <= '0;
      proc_q    <= '0;
    end else begin
      if (item_ready_o) vld_q <= item_valid_i;
      ele_cnt_q <= ele_cnt_d;
      mu_cnt_q  <= mu_cnt_d;
      tau_cnt_q <= tau_cnt_d;
      lep_q     <= lep_d;
      tau_q     <= tau_d;
      lead_q    <= lead_d;
      sub_q     <= sub_d;
      jcnt_q    <= jcnt_d;
      jsum_q    <= jsum_d;
      proc_q    <= proc_d;
    end
  end

endmodule

/* hdl/lte_emit.sv */
module lte_emit import lte_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  snap_t snap_i,
  output logic  emit_free_o,
  output logic  rec_valid_o,
  input  logic  rec_ready_i,
  output rec_t  rec_o
);

  snap_t snap_q;
  logic  busy_q;
  kind_e idx_q;
  logic  fire;
  logic  last;
  obj_t  obj;

  assign last        = !snap_q.passed || (idx_q == KIND_SUB);
  assign fire        = busy_q && rec_ready_i;
  assign emit_free_o = !busy_q || (fire && last);
  assign rec_valid_o = busy_q;

  always_comb begin
    case (idx_q)
      KIND_LEPTON: obj = snap_q.lep;
      KIND_TAU:    obj = snap_q.tau;
      KIND_LEAD:   obj = snap_q.lead;
      KIND_SUB:    obj = snap_q.sub;
      default:     obj = OBJ_NONE;
    endcase
    // Lepton and tau records exist only for passing events, where both are real.
    if ((idx_q == KIND_LEPTON) || (idx_q == KIND_TAU)) begin
      obj.valid = 1'b1;
    end
  end

  always_comb begin
    rec_o.record_kind        = idx_q;
    rec_o.valid_res          = obj.valid;
    rec_o.pt_value           = (idx_q == KIND_SUMMARY) ? snap_q.jet_sum :
                               (obj.valid ? SUM_W'(obj.pt) : '0);
    rec_o.eta_value          = obj.valid ? obj.eta : '0;
    rec_o.phi_value          = obj.valid ? obj.phi : '0;
    rec_o.charge_value       = obj.valid ? obj.chg : '0;
    rec_o.lepton_is_electron = (idx_q == KIND_LEPTON) && obj.ele;
    rec_o.jet_count          = snap_q.jet_count;
    rec_o.passed             = snap_q.passed;
    rec_o.cuts_passed        = snap_q.stage;
    rec_o.event_process      = snap_q.process;
    rec_o.last_record        = last;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= KIND_SUMMARY;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= KIND_SUMMARY;
    end else if (fire) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= kind_e'(idx_q + 3'd1);
      end
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the lepton plus hadronic-tau event selector.
// Beats are planned by the stimulus process into a queue, a driver on the
// falling edge offers them on evt_i, and a monitor on the rising edge folds
// every accepted beat into a predictor of the selector. The records that an
// end beat should produce are queued, and every record beat on rec_o is
// compared field by field with the oldest one waiting.
module tb;
  import lte_pkg::*;

  // Operation codes outside the defined set, which the block must ignore.
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  // A write to an index above the threshold registers must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFC;

  localparam int PHASE_BEATS  = 50;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int JUMBO_JETS   = 24;
  localparam int LIMIT_NS     = 2_000_000;
  localparam int MAX_REPORTS  = 10;

  logic clk_i;
  logic rst_ni;

  lte_item_if evt_if ();
  lte_rec_if  rec_if ();
  lte_cfg_if  cfg_if ();

  lepton_tau_event_selector_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .rec_o  (rec_if),
    .cfg_i  (cfg_if)
  );

  // Beats waiting to be offered, and records the selector still owes us.
  item_t pending_beats[$];
  rec_t  expected_records[$];

  // Predictor copy of the thresholds, updated on every accepted write beat.
  logic [PT_W-1:0] lim_lep_sel, lim_lep_min, lim_jet_min, lim_tau_min;

  // Predictor copy of the event state.
  logic [CNT_W-1:0]  n_ele, n_mu, n_tau;
  obj_t              lep_obj, tau_obj;
  obj_t              top_jet[2];
  logic [JCNT_W-1:0] jet_cnt;
  logic [SUM_W-1:0]  jet_sum;
  logic [PROC_W-1:0] cur_process;

  // Threshold values the stimulus plans for the current phase.
  int thr_plan[4];

  // Idling knobs, in percent of cycles, and the long output hold-off.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_request;
  int          hold_left;

  logic  item_taken;
  item_t next_beat;
  item_t taken_beat;
  rec_t  got_rec;
  rec_t  want_rec;

  int beats_planned;
  int beats_accepted;
  int records_checked;
  int events_passed;
  int cfg_writes;
  int failures;
  int phase;
  int mark;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or a handshake never completes.
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic clear_event();
    n_ele      = '0;
    n_mu       = '0;
    n_tau      = '0;
    lep_obj    = OBJ_NONE;
    tau_obj    = OBJ_NONE;
    top_jet[0] = OBJ_NONE;
    top_jet[1] = OBJ_NONE;
    jet_cnt    = '0;
    jet_sum    = '0;
  endtask

  // Charges are two-bit signed codes, so the code 2 stands for -2.
  function automatic int charge_of(logic [1:0] c);
    return c[1] ? int'(c) - 4 : int'(c);
  endfunction

  // One output record. A missing object, and the object fields of the summary,
  // read as zero; the summary carries the saturated jet pt sum instead.
  function automatic rec_t make_record(kind_e kind, obj_t o, logic [SUM_W-1:0] pt_arg,
                                       logic pass, logic [2:0] stage);
    rec_t r;
    r.record_kind        = kind;
    r.valid_res          = o.valid;
    r.pt_value           = o.valid ? SUM_W'(o.pt) : pt_arg;
    r.eta_value          = o.valid ? o.eta : '0;
    r.phi_value          = o.valid ? o.phi : '0;
    r.charge_value       = o.valid ? o.chg : '0;
    r.lepton_is_electron = (kind == KIND_LEPTON) && o.valid && o.ele;
    r.jet_count          = jet_cnt;
    r.passed             = pass;
    r.cuts_passed        = stage;
    r.event_process      = cur_process;
    r.last_record        = 1'b0;
    return r;
  endfunction

  // Folds one accepted beat into the event state. An end beat runs the cut
  // chain and queues the summary, plus the four object records if it passed.
  task automatic fold_beat(input item_t b);
    obj_t             o;
    stage_e           stage;
    logic             pass;
    logic [SUM_W:0]   wide_sum;
    rec_t             batch[$];
    o.valid = 1'b1;
    o.pt    = b.pt;
    o.eta   = b.eta;
    o.phi   = b.phi;
    o.chg   = b.charge;
    o.ele   = (b.operation == OP_ELECTRON);
    case (b.operation)
      OP_START: begin
        clear_event();
        cur_process = b.proc_num;
      end
      OP_ELECTRON, OP_MUON: begin
        if (b.pt > lim_lep_sel) begin
          if (b.operation == OP_ELECTRON) begin
            if (n_ele != 2'd3) n_ele = n_ele + 1'b1;
          end else begin
            if (n_mu != 2'd3) n_mu = n_mu + 1'b1;
          end
          lep_obj = o;
        end
      end
      OP_JET: begin
        if (b.pt >= lim_jet_min) begin
          o.ele = 1'b0;
          if (b.tau_tag) begin
            if (n_tau != 2'd3) n_tau = n_tau + 1'b1;
            tau_obj = o;
          end else begin
            if (jet_cnt != 8'hFF) jet_cnt = jet_cnt + 1'b1;
            wide_sum = jet_sum + o.pt;
            jet_sum  = (wide_sum > {1'b0, {SUM_W{1'b1}}}) ? {SUM_W{1'b1}} : wide_sum[SUM_W-1:0];
            // Strictly greater pt displaces; a tie stays behind the earlier jet.
            if (!top_jet[0].valid || o.pt > top_jet[0].pt) begin
              top_jet[1] = top_jet[0];
              top_jet[0] = o;
            end else if (!top_jet[1].valid || o.pt > top_jet[1].pt) begin
              top_jet[1] = o;
            end
          end
        end
      end
      OP_END: begin
        stage = STG_NONE;
        if (n_ele <= 2'd1 && n_mu <= 2'd1 && n_ele != n_mu) begin
          stage = STG_LEPTON;
          if (lep_obj.pt >= lim_lep_min) begin
            stage = STG_LEP_PT;
            if (n_tau == 2'd1) begin
              stage = STG_TAU;
              if (charge_of(lep_obj.chg) + charge_of(tau_obj.chg) == 0) begin
                stage = STG_CHARGE;
                if (tau_obj.pt >= lim_tau_min) stage = STG_PASS;
              end
            end
          end
        end
        pass = (stage == STG_PASS);
        batch.push_back(make_record(KIND_SUMMARY, OBJ_NONE, jet_sum, pass, stage));
        if (pass) begin
          events_passed++;
          lep_obj.valid = 1'b1;
          tau_obj.valid = 1'b1;
          batch.push_back(make_record(KIND_LEPTON, lep_obj, '0, pass, stage));
          batch.push_back(make_record(KIND_TAU, tau_obj, '0, pass, stage));
          batch.push_back(make_record(KIND_LEAD, top_jet[0], '0, pass, stage));
          batch.push_back(make_record(KIND_SUB, top_jet[1], '0, pass, stage));
        end
        batch[batch.size() - 1].last_record = 1'b1;
        foreach (batch[i]) expected_records.push_back(batch[i]);
        // The process id survives the end beat; only a start beat replaces it.
        clear_event();
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic string describe(rec_t r);
    return $sformatf({"kind=%0d valid=%0d pt=%0d eta=%0d phi=%0d chg=%0d ele=%0d ",
                      "jets=%0d pass=%0d stage=%0d proc=%0d last=%0d"},
                     r.record_kind, r.valid_res, r.pt_value, r.eta_value, r.phi_value,
                     r.charge_value, r.lepton_is_electron, r.jet_count, r.passed,
                     r.cuts_passed, r.event_process, r.last_record);
  endfunction

  task automatic flag_mismatch(input string why, input rec_t want, input rec_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, why);
      $display("  expected %s", describe(want));
      $display("  actual   %s", describe(got));
    end
  endtask

  // The monitor samples every channel at the rising edge. Within one edge the
  // threshold write is applied first, then the input beat, then the record.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= evt_if.valid && evt_if.ready;

      if (cfg_if.valid && cfg_if.ready) begin
        cfg_writes++;
        case (cfg_if.index)
          CFG_LEP_SEL: lim_lep_sel = cfg_if.data;
          CFG_LEP_MIN: lim_lep_min = cfg_if.data;
          CFG_JET_MIN: lim_jet_min = cfg_if.data;
          CFG_TAU_MIN: lim_tau_min = cfg_if.data;
          default: begin
          end
        endcase
      end

      if (evt_if.valid && evt_if.ready) begin
        taken_beat.operation = evt_if.operation;
        taken_beat.pt        = evt_if.pt;
        taken_beat.eta       = evt_if.eta;
        taken_beat.phi       = evt_if.phi;
        taken_beat.charge    = evt_if.charge;
        taken_beat.tau_tag   = evt_if.tau_tag;
        taken_beat.proc_num  = evt_if.proc_num;
        beats_accepted++;
        fold_beat(taken_beat);
      end

      if (rec_if.valid && rec_if.ready) begin
        got_rec.record_kind        = rec_if.record_kind;
        got_rec.valid_res          = rec_if.valid_res;
        got_rec.pt_value           = rec_if.pt_value;
        got_rec.eta_value          = rec_if.eta_value;
        got_rec.phi_value          = rec_if.phi_value;
        got_rec.charge_value       = rec_if.charge_value;
        got_rec.lepton_is_electron = rec_if.lepton_is_electron;
        got_rec.jet_count          = rec_if.jet_count;
        got_rec.passed             = rec_if.passed;
        got_rec.cuts_passed        = rec_if.cuts_passed;
        got_rec.event_process      = rec_if.event_process;
        got_rec.last_record        = rec_if.last_record;
        records_checked++;
        if (expected_records.size() == 0) begin
          flag_mismatch("record beat with nothing expected", '0, got_rec);
        end else begin
          want_rec = expected_records.pop_front();
          if (got_rec.record_kind !== want_rec.record_kind ||
              got_rec.valid_res !== want_rec.valid_res ||
              got_rec.pt_value !== want_rec.pt_value ||
              got_rec.eta_value !== want_rec.eta_value ||
              got_rec.phi_value !== want_rec.phi_value ||
              got_rec.charge_value !== want_rec.charge_value ||
              got_rec.lepton_is_electron !== want_rec.lepton_is_electron ||
              got_rec.jet_count !== want_rec.jet_count ||
              got_rec.passed !== want_rec.passed ||
              got_rec.cuts_passed !== want_rec.cuts_passed ||
              got_rec.event_process !== want_rec.event_process ||
              got_rec.last_record !== want_rec.last_record) begin
            flag_mismatch("record beat differs", want_rec, got_rec);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver, receiver and hold-off
  // ---------------------------------------------------------------------------

  // A beat on offer stays put until the monitor saw it taken; only then may the
  // driver idle or move on to the next planned beat.
  always @(negedge clk_i) begin
    if (rst_ni && !(evt_if.valid && !item_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat = pending_beats.pop_front();
        evt_if.valid     <= 1'b1;
        evt_if.operation <= next_beat.operation;
        evt_if.pt        <= next_beat.pt;
        evt_if.eta       <= next_beat.eta;
        evt_if.phi       <= next_beat.phi;
        evt_if.charge    <= next_beat.charge;
        evt_if.tau_tag   <= next_beat.tau_tag;
        evt_if.proc_num  <= next_beat.proc_num;
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rec_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Counts out the long hold-off on rec_o. While it runs the sender keeps
  // offering beats, so the record buffer fills and the block must stall evt_i.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic enqueue_beat(input item_t b);
    // Beats with an undefined operation are ignored by the block and do not
    // count toward the planned amount.
    if (b.operation <= OP_END) beats_planned++;
    pending_beats.push_back(b);
  endtask

  task automatic push_beat(input logic [2:0] op, input int pt, input int eta, input int phi,
                           input int chg, input bit tag, input int proc);
    item_t b;
    b.operation = op;
    b.pt        = PT_W'(pt);
    b.eta       = ETA_W'(eta);
    b.phi       = PHI_W'(phi);
    b.charge    = CHG_W'(chg);
    b.tau_tag   = tag;
    b.proc_num  = PROC_W'(proc);
    enqueue_beat(b);
  endtask

  function automatic item_t random_beat(logic [2:0] op);
    item_t b;
    b.operation = op;
    b.pt        = PT_W'($urandom);
    b.eta       = ETA_W'($urandom);
    b.phi       = PHI_W'($urandom);
    b.charge    = CHG_W'($urandom);
    b.tau_tag   = 1'($urandom);
    b.proc_num  = PROC_W'($urandom);
    return b;
  endfunction

  // Mostly lands on, just below or up to 300 above a threshold, sometimes anywhere in range.
  function automatic logic [PT_W-1:0] pick_pt(int base_pt);
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 65535);
      1:       v = base_pt + int'($urandom_range(0, 2)) - 1;
      default: v = base_pt + int'($urandom_range(0, 300));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return PT_W'(v);
  endfunction

  // Plans one event. Most are well formed and shaped to get deep into the cut
  // chain: one selected lepton, one tau of opposite charge and a few jets, in
  // shuffled order. A tenth are pure noise, and a tenth lack their end beat.
  task automatic queue_random_event();
    item_t             objs[$];
    item_t             b;
    logic signed [1:0] lep_q;
    int                n, k, j, lep_base, tau_base;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) enqueue_beat(random_beat(3'($urandom)));
      return;
    end
    lep_base = (thr_plan[0] + 1 > thr_plan[1]) ? thr_plan[0] + 1 : thr_plan[1];
    tau_base = (thr_plan[2] > thr_plan[3]) ? thr_plan[2] : thr_plan[3];
    lep_q    = $urandom_range(0, 1) ? 2'sb01 : 2'sb11;

    n = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 4);
    repeat (n) begin
      b = random_beat($urandom_range(0, 1) ? OP_ELECTRON : OP_MUON);
      b.pt = pick_pt(lep_base);
      if ($urandom_range(0, 9) != 0) b.charge = lep_q;
      objs.push_back(b);
    end
    n = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 3);
    repeat (n) begin
      b = random_beat(OP_JET);
      b.tau_tag = 1'b1;
      b.pt = pick_pt(tau_base);
      if ($urandom_range(0, 9) != 0) b.charge = -lep_q;
      objs.push_back(b);
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      b = random_beat(OP_JET);
      b.tau_tag = 1'b0;
      b.pt = pick_pt(thr_plan[2]);
      objs.push_back(b);
    end
    for (k = objs.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      b = objs[k];
      objs[k] = objs[j];
      objs[j] = b;
    end

    enqueue_beat(random_beat(OP_START));
    foreach (objs[i]) enqueue_beat(objs[i]);
    if ($urandom_range(0, 9) != 0) enqueue_beat(random_beat(OP_END));
  endtask

  // Thresholds only change while the block is idle, so every write goes out
  // between phases, after the last owed record and the drain wait in settle.
  task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DAT_W'(value);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_beats.size() != 0 || evt_if.valid || expected_records.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    evt_if.valid     = 1'b0;
    evt_if.operation = OP_START;
    evt_if.pt        = '0;
    evt_if.eta       = '0;
    evt_if.phi       = '0;
    evt_if.charge    = '0;
    evt_if.tau_tag   = 1'b0;
    evt_if.proc_num  = '0;
    rec_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_LEP_SEL;
    cfg_if.data      = '0;
    hold_request     = 1'b0;
    hold_left        = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    lim_lep_sel      = LEP_SEL_RST;
    lim_lep_min      = LEP_MIN_RST;
    lim_jet_min      = JET_MIN_RST;
    lim_tau_min      = TAU_MIN_RST;
    cur_process      = '0;
    clear_event();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phases: reset thresholds with no idling, all thresholds at zero with a
    // mostly idle sender, all at the top of the range with a mostly stalled
    // receiver, random thresholds with both idling, and finally the reset
    // thresholds again under the long output hold-off.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          thr_plan       = '{0, 0, 0, 0};
          send_idle_pct  = 72;
          recv_stall_pct = 0;
        end
        2: begin
          thr_plan       = '{65535, 65535, 65535, 65535};
          send_idle_pct  = 0;
          recv_stall_pct = 72;
        end
        3: begin
          thr_plan       = '{$urandom_range(0, 150), $urandom_range(0, 300),
                             $urandom_range(0, 200), $urandom_range(0, 300)};
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
        default: begin
          thr_plan       = '{int'(LEP_SEL_RST), int'(LEP_MIN_RST),
                             int'(JET_MIN_RST), int'(TAU_MIN_RST)};
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_threshold(CFG_LEP_SEL, thr_plan[0]);
      write_threshold(CFG_LEP_MIN, thr_plan[1]);
      write_threshold(CFG_JET_MIN, thr_plan[2]);
      write_threshold(CFG_TAU_MIN, thr_plan[3]);
      write_threshold((phase == 0) ? CFG_UNUSED_HI : CFG_IDX_W'($urandom_range(4, 255)),
                      $urandom_range(0, 65535));

      if (phase == 0) begin
        // Objects ahead of any start beat land in the current event, which then
        // passes: two equal leading jets, and a jet pt sum above 16 bits.
        push_beat(OP_ELECTRON, 100, -2048, -4096, -1, 1'b0, 0);
        push_beat(OP_JET, 65535, 2047, 4095, 1, 1'b1, 0);
        push_beat(OP_JET, 65535, 1, -1, 0, 1'b0, 0);
        push_beat(OP_JET, 65535, -1, 1, 1, 1'b0, 0);
        push_beat(OP_END, 0, 0, 0, 0, 1'b0, 0);
        // A tau charge code of 2 counts as -2, so the charge cut fails. The
        // undefined operations in between must leave no trace.
        push_beat(OP_START, 0, 0, 0, 0, 1'b0, 1023);
        push_beat(OP_MUON, 81, 5, 7, 1, 1'b1, 1023);
        push_beat(OP_JET, 90, -3, 9, 2, 1'b1, 0);
        push_beat(OP_UNDEF_LO, 65535, 2047, 4095, -1, 1'b1, 1023);
        push_beat(OP_UNDEF_HI, 0, -2048, -4096, 0, 1'b0, 0);
        push_beat(OP_END, 65535, -1, -1, -1, 1'b1, 1023);
        // An empty event stops at the first stage.
        push_beat(OP_START, 0, 0, 0, 0, 1'b0, 0);
        push_beat(OP_END, 0, 0, 0, 0, 1'b0, 0);
        // Passing event with a single counted jet: the subleading record has
        // to come out as a missing object. The jet just under threshold is lost.
        push_beat(OP_START, 0, 0, 0, 0, 1'b0, 512);
        push_beat(OP_MUON, 200, 100, -200, -1, 1'b0, 0);
        push_beat(OP_JET, 80, -50, 300, 1, 1'b1, 0);
        push_beat(OP_JET, 79, 10, 10, 1, 1'b0, 0);
        push_beat(OP_JET, 80, 20, -20, -1, 1'b0, 0);
        push_beat(OP_END, 0, 0, 0, 0, 1'b0, 0);
        // Four electrons saturate the two-bit lepton count.
        push_beat(OP_START, 0, 0, 0, 0, 1'b0, 341);
        repeat (4) push_beat(OP_ELECTRON, 61, 0, 0, 1, 1'b0, 0);
        push_beat(OP_MUON, 61, 0, 0, -1, 1'b0, 0);
        push_beat(OP_END, 0, 0, 0, 0, 1'b0, 0);
      end

      if (phase == 1) begin
        // One event of near full-scale jets drives the jet pt sum into saturation.
        push_beat(OP_START, 0, 0, 0, 0, 1'b0, $urandom_range(0, 1023));
        push_beat(OP_ELECTRON, 65535, 0, 0, 1, 1'b0, 0);
        push_beat(OP_JET, 65535, 0, 0, -1, 1'b1, 0);
        repeat (JUMBO_JETS) begin
          push_beat(OP_JET, 65535 - int'($urandom_range(0, 255)),
                    $urandom_range(0, 4095), $urandom_range(0, 8191), $urandom_range(0, 3),
                    1'b0, 0);
        end
        push_beat(OP_END, 0, 0, 0, 0, 1'b0, 0);
      end

      if (phase == 4) begin
        @(negedge clk_i);
        hold_request = 1'b1;
        @(negedge clk_i);
        hold_request = 1'b0;
      end

      mark = beats_planned;
      while (beats_planned - mark < PHASE_BEATS) queue_random_event();
      settle();
    end

    if (expected_records.size() != 0) failures++;

    $display("Run covered %0d input beats and %0d checked records; %0d events passed all cuts.",
             beats_accepted, records_checked, events_passed);
    $display("Thresholds written %0d times over five phases of idling, stalls and a long hold.",
             cfg_writes);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lte_pkg.sv
hdl/lte_item_if.sv
hdl/lte_rec_if.sv
hdl/lte_cfg_if.sv
hdl/lte_accum.sv
hdl/lte_emit.sv
hdl/lepton_tau_event_selector_core.sv
verif/tb.sv
